@@ sv/cfa_pkg.sv @@
// Shared types and codes for the contiguous fit allocator.
// No dependencies; cfa_runs and contiguous_fit_allocator import this package.
package cfa_pkg;

    // Default geometry of the unit store.
    localparam int DEF_MEM_UNITS = 256;
    localparam int DEF_LIFE_BITS = 16;

    // Width that holds any unit index or run length up to 65536.
    localparam int RUN_BITS = 17;

    // Action codes.
    localparam logic [1:0] ACT_ALLOC = 2'd0;
    localparam logic [1:0] ACT_TICK  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;
    localparam logic [1:0] ACT_QUERY = 2'd3;

    // Placement strategies; the last code is unused and an allocate with it fails.
    localparam logic [1:0] STR_BEST  = 2'd0;
    localparam logic [1:0] STR_FIRST = 2'd1;
    localparam logic [1:0] STR_NEXT  = 2'd2;
    localparam logic [1:0] STR_NONE  = 2'd3;

    // Count limits.
    localparam logic [8:0] PROBE_MAX = 9'd511;
    localparam logic [7:0] FRAG_MAX  = 8'd255;

    // A free run that closed in this cycle.
    typedef struct packed {
        logic                close;
        logic [RUN_BITS-1:0] start;
        logic [RUN_BITS-1:0] len;
    } t_run;

endpackage

@@ sv/cfa_cell.sv @@
// One unit of the store: holds a remaining lifetime and passes it to its neighbor.
// Depends on nothing but its ports.
module cfa_cell #(
    parameter int LIFE_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_clear,
    input  logic                 i_wr,
    input  logic [LIFE_BITS-1:0] i_life,
    input  logic                 i_tick,
    input  logic                 i_shift,
    input  logic [LIFE_BITS-1:0] i_from,
    output logic [LIFE_BITS-1:0] o_val
);

    logic [LIFE_BITS-1:0] r_val;

    // Clear wins over a write, a write over a tick, a tick over a shift.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_val <= '0;
        end else if (i_wr) begin
            r_val <= i_life;
        end else if (i_tick) begin
            if (r_val != '0) begin
                r_val <= r_val - 1'b1;
            end
        end else if (i_shift) begin
            r_val <= i_from;
        end
    end

    assign o_val = r_val;

endmodule

@@ sv/cfa_runs.sv @@
// Free run detector: follows the head of the cell ring and reports each closed run.
// Depends on cfa_pkg for the run word type.
module cfa_runs #(
    parameter int MEM_UNITS = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_init,
    input  logic                              i_en,
    input  logic                              i_free,
    input  logic                              i_brk,
    input  logic [$clog2(MEM_UNITS+1)-1:0]    i_pos,
    output cfa_pkg::t_run                     o_run
);
    import cfa_pkg::*;

    localparam int LW = $clog2(MEM_UNITS + 1);

    logic          r_in_run;
    logic [LW-1:0] r_start;
    logic [LW-1:0] r_len;

    // A run closes on a busy unit, at the window edge, or past the top.
    always_comb begin
        o_run.close = i_en && r_in_run && (!i_free || i_brk);
        o_run.start = RUN_BITS'(r_start);
        o_run.len   = RUN_BITS'(r_len);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_init) begin
            r_in_run <= 1'b0;
        end else if (i_en) begin
            r_in_run <= i_free;
        end
    end

    // Start and length of the open run.
    always_ff @(posedge i_clk) begin
        if (i_en && i_free) begin
            if (!r_in_run || i_brk) begin
                r_start <= i_pos;
                r_len   <= LW'(1);
            end else begin
                r_len   <= r_len + 1'b1;
            end
        end
    end

endmodule

@@ sv/contiguous_fit_allocator.sv @@
// Contiguous fit allocator: a ring of lifetime cells, a run detector and the control.
// Depends on cfa_pkg, cfa_cell and cfa_runs.
//
// Usage: one word on s_axis gives an action. Allocate searches the free runs
// with best, first or next fit and fills the chosen cells with the lifetime;
// tick lowers every nonzero cell; clear frees every cell; query counts free runs
// no longer than fragment_limit. Each action returns one word on m_axis.
// The configuration channel writes fragment_limit; it is always ready.
// Allocate and query rotate the ring once past the run detector; an allocate
// then writes the chosen cells, and every action loads its result into the
// output register. Tick, clear and a rejected allocate skip the scan. The
// ring rotation sets the rate; one item is in work at a time, and a new item
// is taken while the previous result still waits in the output register.
// Reset empties every cell, zeroes the next fit position and fragment_limit.
// A stalled receiver holds the result; the block then finishes its current
// item and waits with its input closed.
module contiguous_fit_allocator #(
    parameter int MEM_UNITS = cfa_pkg::DEF_MEM_UNITS,
    parameter int LIFE_BITS = cfa_pkg::DEF_LIFE_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // action[1:0], strategy[3:2], request_size[12:4], lifetime[28:13]
    input  logic [31:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[0], runs_probed[9:1], start_unit[17:10], fragment_total[25:18]
    output logic [31:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [8:0]  i_cfg_data
);
    import cfa_pkg::*;

    localparam int LW   = $clog2(MEM_UNITS + 1);
    localparam int IW   = $clog2(MEM_UNITS);
    localparam int CMPW = (LW > 9) ? LW : 9;
    localparam int EW   = CMPW + 1;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_WRITE = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]           r_state, n_state;
    logic [LW-1:0]        r_k;
    logic [LW-1:0]        r_pos;
    logic [8:0]           r_limit;
    logic [1:0]           r_act, r_strat;
    logic [8:0]           r_need;
    logic [LIFE_BITS-1:0] r_life;

    // Search results: window A (or the whole store), window B below next fit.
    logic                 r_found_a, r_found_b, r_done_a;
    logic [IW-1:0]        r_at_a, r_at_b;
    logic [8:0]           r_prb_a, r_prb_b;
    logic [LW-1:0]        r_best;
    logic [7:0]           r_frags;

    logic                 r_o_valid, r_o_status;
    logic [8:0]           r_o_probes;
    logic [7:0]           r_o_start, r_o_frags;

    logic                 w_accept, w_scan, w_free, w_brk, w_reject;
    logic [1:0]           w_act, w_strat;
    logic [8:0]           w_need;
    logic [31:0]          w_life32;
    logic [LIFE_BITS-1:0] w_life [MEM_UNITS];
    logic [MEM_UNITS-1:0] w_wr;
    t_run                 w_run;
    logic [CMPW-1:0]      w_len, w_needx, w_bestx, w_limx;
    logic [IW-1:0]        w_rs;
    logic                 w_hi;
    logic                 w_ok;
    logic [IW-1:0]        w_at;
    logic [8:0]           w_prb;
    logic [9:0]           w_sum;
    logic [EW-1:0]        w_at_x, w_end_x;
    logic [31:0]          w_at32;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_act         = s_axis_tdata[1:0];
    assign w_strat       = s_axis_tdata[3:2];
    assign w_need        = s_axis_tdata[12:4];
    assign w_life32      = 32'(s_axis_tdata[28:13]);
    assign w_reject      = (w_need == 9'd0) || (w_strat == STR_NONE);

    // The cell ring; cell 0 is the head the run detector watches.
    assign w_scan = (r_state == S_SCAN) && (r_k != LW'(MEM_UNITS));
    assign w_at_x  = EW'(w_at);
    assign w_end_x = EW'(w_at) + EW'(r_need);

    for (genvar gi = 0; gi < MEM_UNITS; gi++) begin : g_cell
        assign w_wr[gi] = (r_state == S_WRITE) && w_ok && (r_act == ACT_ALLOC)
                        && (EW'(gi) >= w_at_x) && (EW'(gi) < w_end_x);
        cfa_cell #(
            .LIFE_BITS(LIFE_BITS)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_clear(w_accept && (w_act == ACT_CLEAR)),
            .i_wr   (w_wr[gi]),
            .i_life (r_life),
            .i_tick (w_accept && (w_act == ACT_TICK)),
            .i_shift(w_scan),
            .i_from (w_life[(gi + 1) % MEM_UNITS]),
            .o_val  (w_life[gi])
        );
    end

    // Run detection; next fit cuts runs at its start position.
    assign w_free = w_scan && (w_life[0] == '0);
    assign w_brk  = (r_strat == STR_NEXT) && (r_act == ACT_ALLOC) && (r_k == r_pos);

    cfa_runs #(
        .MEM_UNITS(MEM_UNITS)
    ) u_runs (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_init (w_accept),
        .i_en   (r_state == S_SCAN),
        .i_free (w_free),
        .i_brk  (w_brk),
        .i_pos  (r_k),
        .o_run  (w_run)
    );

    assign w_len   = CMPW'(w_run.len[LW-1:0]);
    assign w_rs    = w_run.start[IW-1:0];
    assign w_needx = CMPW'(r_need);
    assign w_bestx = CMPW'(r_best);
    assign w_limx  = CMPW'(r_limit);
    assign w_hi    = (r_strat != STR_NEXT) || (LW'(w_run.start) >= r_pos);

    // Final outcome of the search.
    always_comb begin
        w_sum = {1'b0, r_prb_a} + {1'b0, r_prb_b};
        if (r_found_a || (r_strat != STR_NEXT)) begin
            w_ok  = r_found_a;
            w_at  = r_at_a;
            w_prb = r_prb_a;
        end else begin
            w_ok  = r_found_b;
            w_at  = r_at_b;
            w_prb = w_sum[9] ? PROBE_MAX : w_sum[8:0];
        end
        w_at32 = 32'(w_at);
    end

    // Control sequence.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if ((w_act == ACT_QUERY) || ((w_act == ACT_ALLOC) && !w_reject)) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                if (r_k == LW'(MEM_UNITS)) begin
                    n_state = (r_act == ACT_ALLOC) ? S_WRITE : S_DONE;
                end
            end
            S_WRITE: n_state = S_DONE;
            S_DONE: begin
                if (!r_o_valid || m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pos   <= '0;
            r_limit <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_limit <= i_cfg_data;
            end
            if ((r_state == S_WRITE) && w_ok && (r_strat == STR_NEXT)) begin
                r_pos <= w_end_x[LW-1:0];
            end
        end
    end

    // Item fields and unit counter.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_act   <= w_act;
            r_strat <= w_strat;
            r_need  <= w_need;
            r_life  <= w_life32[LIFE_BITS-1:0];
            r_k     <= '0;
        end else if (r_state == S_SCAN) begin
            r_k     <= r_k + 1'b1;
        end
    end

    // Evaluate each closed run for the action in work.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_accept) begin
            r_found_a <= 1'b0;
            r_found_b <= 1'b0;
            r_done_a  <= 1'b0;
            r_prb_a   <= '0;
            r_prb_b   <= '0;
            r_frags   <= '0;
            r_at_a    <= '0;
            r_at_b    <= '0;
            r_best    <= '0;
        end else if (w_run.close) begin
            if (r_act == ACT_QUERY) begin
                if ((w_len <= w_limx) && (r_frags != FRAG_MAX)) begin
                    r_frags <= r_frags + 1'b1;
                end
            end else if (r_strat == STR_BEST) begin
                if (!r_done_a) begin
                    if (r_prb_a != PROBE_MAX) r_prb_a <= r_prb_a + 1'b1;
                    if (w_len == w_needx) begin
                        r_done_a  <= 1'b1;
                        r_found_a <= 1'b1;
                        r_at_a    <= w_rs;
                    end else if ((w_len >= w_needx) && (!r_found_a || (w_len < w_bestx))) begin
                        r_found_a <= 1'b1;
                        r_best    <= w_run.len[LW-1:0];
                        r_at_a    <= w_rs;
                    end
                end
            end else if (w_hi) begin
                if (!r_found_a) begin
                    if (r_prb_a != PROBE_MAX) r_prb_a <= r_prb_a + 1'b1;
                    if (w_len >= w_needx) begin
                        r_found_a <= 1'b1;
                        r_at_a    <= w_rs;
                    end
                end
            end else begin
                if (!r_found_b) begin
                    if (r_prb_b != PROBE_MAX) r_prb_b <= r_prb_b + 1'b1;
                    if (w_len >= w_needx) begin
                        r_found_b <= 1'b1;
                        r_at_b    <= w_rs;
                    end
                end
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if ((r_state == S_DONE) && (!r_o_valid || m_axis_tready)) begin
            r_o_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && (!r_o_valid || m_axis_tready)) begin
            r_o_status <= (r_act == ACT_ALLOC) && !w_ok;
            r_o_probes <= (r_act == ACT_ALLOC) ? w_prb : 9'd0;
            r_o_start  <= ((r_act == ACT_ALLOC) && w_ok) ? w_at32[7:0] : 8'd0;
            r_o_frags  <= r_frags;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {6'd0, r_o_frags, r_o_start, r_o_probes, r_o_status};

    // Checks on the control sequence.
    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_k <= LW'(MEM_UNITS)))
        else $error("scan counter past the top of the store");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= LW'(MEM_UNITS))
        else $error("next fit position past the top of the store");

    a_fail_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[0]) |-> (m_axis_tdata[17:10] == 8'd0))
        else $error("failed allocation reports a start unit");

    a_scan_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SCAN) && (r_k == LW'(MEM_UNITS)) && (r_act == ACT_ALLOC))
        |=> (r_state == S_WRITE))
        else $error("allocate scan did not move to the write cycle");

endmodule
